[src/stream_substring_replace_assert.svh]
// Assertion macros shared by the stream substring replace RTL.
// Depends on i_clk and i_rst_n being visible in the module that uses them.
`ifndef STREAM_SUBSTRING_REPLACE_ASSERT_SVH
`define STREAM_SUBSTRING_REPLACE_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted
`define SSR_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted
`define SSR_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[src/ssr_pkg.sv]
// Shared types, constants and helper functions for the substring replacer.
// No dependencies; used by the window cells, output cells and top level.
package ssr_pkg;

    localparam int MAX_PATTERN     = 8;
    localparam int MAX_REPLACEMENT = 8;
    // Longest burst one beat can cause
    localparam int MAX_BURST = (MAX_PATTERN > MAX_REPLACEMENT) ? MAX_PATTERN
                                                               : MAX_REPLACEMENT;
    // Output chain holds one full burst on top of a burst still draining
    localparam int OUT_DEPTH = 2 * MAX_BURST;

    localparam int LEN_W   = 4;
    localparam int FILL_W  = $clog2(MAX_PATTERN);
    localparam int BURST_W = $clog2(MAX_BURST);
    localparam int CNT_W   = $clog2(OUT_DEPTH + 1);
    localparam int ADDR_W  = 5;
    localparam int DATA_W  = 64;

    typedef enum logic [1:0] {
        REG_PATTERN_BYTES      = 2'd0,
        REG_PATTERN_LENGTH     = 2'd1,
        REG_REPLACEMENT_BYTES  = 2'd2,
        REG_REPLACEMENT_LENGTH = 2'd3
    } t_reg_idx;

    // One result beat as it sits in the output chain
    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } t_beat;

    // Common controls for the window cells
    typedef struct packed {
        logic write;
        logic shift;
    } t_win_ctl;

    // Per-cell controls for the output chain
    typedef struct packed {
        logic load;
        logic shift;
    } t_out_ctl;

    // Clamp the pattern length to 1..MAX_PATTERN
    function automatic logic [LEN_W-1:0] eff_pattern_len(input logic [LEN_W-1:0] len);
        logic [LEN_W-1:0] r;
        r = len;
        if (r == '0) r = LEN_W'(1);
        if (r > LEN_W'(MAX_PATTERN)) r = LEN_W'(MAX_PATTERN);
        return r;
    endfunction

    // Clamp the replacement length to 0..MAX_REPLACEMENT
    function automatic logic [LEN_W-1:0] eff_repl_len(input logic [LEN_W-1:0] len);
        logic [LEN_W-1:0] r;
        r = len;
        if (r > LEN_W'(MAX_REPLACEMENT)) r = LEN_W'(MAX_REPLACEMENT);
        return r;
    endfunction

endpackage

[src/ssr_win_cell.sv]
// One byte cell of the pending-text window, with its pattern compare.
// Depends on ssr_pkg for the control struct.
module ssr_win_cell (
    input  logic               i_clk,
    input  logic               i_sel,
    input  ssr_pkg::t_win_ctl  i_ctl,
    input  logic [7:0]         i_text_byte,
    input  logic [7:0]         i_pat_byte,
    input  logic [7:0]         i_nb_cand,
    output logic [7:0]         o_cand,
    output logic               o_eq
);

    logic [7:0] r_byte;
    logic [7:0] n_byte;

    // Contents as seen with the incoming byte placed at the fill position
    assign o_cand = i_sel ? i_text_byte : r_byte;
    assign o_eq   = (o_cand == i_pat_byte);

    // Take the neighbor's byte on a shift, the incoming byte on a write
    always_comb begin
        n_byte = r_byte;
        if (i_ctl.shift) begin
            n_byte = i_nb_cand;
        end else if (i_ctl.write && i_sel) begin
            n_byte = i_text_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        r_byte <= n_byte;
    end

endmodule

[src/ssr_out_cell.sv]
// One entry of the output chain; shifts toward the head as beats leave.
// Depends on ssr_pkg for the beat and control structs.
module ssr_out_cell (
    input  logic               i_clk,
    input  ssr_pkg::t_out_ctl  i_ctl,
    input  ssr_pkg::t_beat     i_load_beat,
    input  ssr_pkg::t_beat     i_nb_beat,
    output ssr_pkg::t_beat     o_beat
);

    ssr_pkg::t_beat r_beat;
    ssr_pkg::t_beat n_beat;

    // Load a fresh beat, else advance from the neighbor, else hold
    always_comb begin
        n_beat = r_beat;
        if (i_ctl.load) begin
            n_beat = i_load_beat;
        end else if (i_ctl.shift) begin
            n_beat = i_nb_beat;
        end
    end

    always_ff @(posedge i_clk) begin
        r_beat <= n_beat;
    end

    assign o_beat = r_beat;

endmodule

[src/stream_substring_replace.sv]
// Top level of the streaming find-and-replace-all block.
// Depends on ssr_pkg, ssr_win_cell, ssr_out_cell and the assertion header.
//
// Usage:
//   Input channel (i_in_valid / o_in_ready) carries one text byte per beat and
//   an end-of-text flag. Output channel (o_out_valid / i_out_ready) carries the
//   rewritten text one byte per beat, with o_last_of_text on the final byte.
//   The pattern and replacement are set through the APB port while idle.
//   Bytes a beat yields are loaded into the output chain when the beat is taken.
//   Throughput with i_out_ready high: one input beat per cycle while each beat
//   yields at most one output byte. A match or an end-of-text flush yields a
//   burst of up to eight bytes that drains at one per cycle through a 16-entry
//   output chain; input is taken while the chain holds eight entries or fewer,
//   so the input stalls only once bursts arrive faster than the chain drains.
//   Receiver stall: bytes wait in the output chain; once it holds more than
//   eight, o_in_ready drops until it drains.
//   Reset: empties the window and the output chain at once and returns the
//   registers to pattern 0, length 1, replacement 0, length 0. No clearing
//   pass is needed.
`include "stream_substring_replace_assert.svh"

module stream_substring_replace (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // input stream
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  logic [7:0]                  i_text_byte,
    input  logic                        i_end_of_text,
    // output stream
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output logic [7:0]                  o_out_byte,
    output logic                        o_last_of_text,
    // configuration
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [ssr_pkg::ADDR_W-1:0]  paddr,
    input  logic [ssr_pkg::DATA_W-1:0]  pwdata,
    output logic [ssr_pkg::DATA_W-1:0]  prdata,
    output logic                        pready
);

    localparam int NP = ssr_pkg::MAX_PATTERN;
    localparam int NO = ssr_pkg::OUT_DEPTH;

    // Configuration registers
    logic [8*NP-1:0]                      r_pat;
    logic [ssr_pkg::LEN_W-1:0]            r_plen;
    logic [8*ssr_pkg::MAX_REPLACEMENT-1:0] r_repl;
    logic [ssr_pkg::LEN_W-1:0]            r_rlen;

    logic [ssr_pkg::FILL_W-1:0]           r_fill;
    logic [ssr_pkg::FILL_W-1:0]           n_fill;
    logic [ssr_pkg::CNT_W-1:0]            r_count;
    logic [ssr_pkg::CNT_W-1:0]            n_count;

    logic                       cfg_wr;
    ssr_pkg::t_reg_idx          cfg_idx;
    logic [ssr_pkg::LEN_W-1:0]  plen;
    logic [ssr_pkg::LEN_W-1:0]  rlen;
    logic [ssr_pkg::LEN_W-1:0]  new_plen;
    logic                       in_acc;
    logic                       pop;
    logic                       full;
    logic                       match;
    logic [ssr_pkg::LEN_W-1:0]  burst_n;
    logic [ssr_pkg::CNT_W-1:0]  base;

    logic [7:0]       cand   [NP];
    logic [NP-1:0]    eq;
    logic [NP-1:0]    in_use;
    logic [NP-1:0]    sel;
    ssr_pkg::t_win_ctl win_ctl;

    ssr_pkg::t_beat   burst  [ssr_pkg::MAX_BURST];
    ssr_pkg::t_beat   ochain [NO];
    ssr_pkg::t_out_ctl out_ctl [NO];

    // APB access decode
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_idx = ssr_pkg::t_reg_idx'(paddr[4:3]);
    assign new_plen = ssr_pkg::eff_pattern_len(pwdata[ssr_pkg::LEN_W-1:0]);

    always_comb begin
        case (cfg_idx)
            ssr_pkg::REG_PATTERN_BYTES:      prdata = r_pat;
            ssr_pkg::REG_PATTERN_LENGTH:     prdata = ssr_pkg::DATA_W'(r_plen);
            ssr_pkg::REG_REPLACEMENT_BYTES:  prdata = r_repl;
            ssr_pkg::REG_REPLACEMENT_LENGTH: prdata = ssr_pkg::DATA_W'(r_rlen);
            default:                         prdata = '0;
        endcase
    end

    // Write configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pat  <= '0;
            r_plen <= ssr_pkg::LEN_W'(1);
            r_repl <= '0;
            r_rlen <= '0;
        end else if (cfg_wr) begin
            case (cfg_idx)
                ssr_pkg::REG_PATTERN_BYTES:      r_pat  <= pwdata;
                ssr_pkg::REG_PATTERN_LENGTH:     r_plen <= pwdata[ssr_pkg::LEN_W-1:0];
                ssr_pkg::REG_REPLACEMENT_BYTES:  r_repl <= pwdata;
                ssr_pkg::REG_REPLACEMENT_LENGTH: r_rlen <= pwdata[ssr_pkg::LEN_W-1:0];
                default: ;
            endcase
        end
    end

    assign plen = ssr_pkg::eff_pattern_len(r_plen);
    assign rlen = ssr_pkg::eff_repl_len(r_rlen);

    // Handshakes
    assign o_in_ready  = (r_count <= ssr_pkg::CNT_W'(NO - ssr_pkg::MAX_BURST));
    assign in_acc      = i_in_valid && o_in_ready;
    assign o_out_valid = (r_count != '0);
    assign pop         = o_out_valid && i_out_ready;

    // Window: a row of cells, the incoming byte lands at the fill position
    assign full = ((ssr_pkg::LEN_W'(r_fill) + ssr_pkg::LEN_W'(1)) == plen);

    always_comb begin
        for (int i = 0; i < NP; i++) begin
            sel[i]    = (ssr_pkg::FILL_W'(i) == r_fill);
            in_use[i] = (ssr_pkg::LEN_W'(i) < plen);
        end
    end

    assign match = full && (&(eq | ~in_use));

    assign win_ctl.shift = in_acc && full && !match && !i_end_of_text;
    assign win_ctl.write = in_acc && !full && !i_end_of_text;

    generate
        for (genvar g = 0; g < NP; g++) begin : g_win
            logic [7:0] nb;
            if (g == NP - 1) begin : g_tail
                assign nb = '0;
            end else begin : g_link
                assign nb = cand[g+1];
            end
            ssr_win_cell u_cell (
                .i_clk       (i_clk),
                .i_sel       (sel[g]),
                .i_ctl       (win_ctl),
                .i_text_byte (i_text_byte),
                .i_pat_byte  (r_pat[8*g +: 8]),
                .i_nb_cand   (nb),
                .o_cand      (cand[g]),
                .o_eq        (eq[g])
            );
        end
    endgenerate

    // Advance the fill count; a pattern length write may drop pending bytes
    always_comb begin
        n_fill = r_fill;
        if (cfg_wr && cfg_idx == ssr_pkg::REG_PATTERN_LENGTH) begin
            if (ssr_pkg::LEN_W'(r_fill) >= new_plen) n_fill = '0;
        end else if (in_acc) begin
            if (match || i_end_of_text) begin
                n_fill = '0;
            end else if (!full) begin
                n_fill = r_fill + ssr_pkg::FILL_W'(1);
            end
        end
    end

    // Burst: replacement on a match, else pending bytes from the head
    always_comb begin
        if (match) begin
            burst_n = rlen;
        end else if (i_end_of_text) begin
            burst_n = ssr_pkg::LEN_W'(r_fill) + ssr_pkg::LEN_W'(1);
        end else if (full) begin
            burst_n = ssr_pkg::LEN_W'(1);
        end else begin
            burst_n = '0;
        end
        for (int k = 0; k < ssr_pkg::MAX_BURST; k++) begin
            burst[k].data = match ? r_repl[8*k +: 8] : cand[k];
            burst[k].last = i_end_of_text &&
                            (ssr_pkg::LEN_W'(k) + ssr_pkg::LEN_W'(1) == burst_n);
        end
    end

    // Output chain: new beats append behind what stays after a pop
    assign base = r_count - ssr_pkg::CNT_W'(pop);

    generate
        for (genvar j = 0; j < NO; j++) begin : g_out
            logic [ssr_pkg::CNT_W-1:0] off;
            ssr_pkg::t_beat            nb;
            assign off = ssr_pkg::CNT_W'(j) - base;
            assign out_ctl[j].load  = in_acc && (ssr_pkg::CNT_W'(j) >= base) &&
                                      (off < ssr_pkg::CNT_W'(burst_n));
            assign out_ctl[j].shift = pop;
            if (j == NO - 1) begin : g_tail
                assign nb = '0;
            end else begin : g_link
                assign nb = ochain[j+1];
            end
            ssr_out_cell u_cell (
                .i_clk       (i_clk),
                .i_ctl       (out_ctl[j]),
                .i_load_beat (burst[off[ssr_pkg::BURST_W-1:0]]),
                .i_nb_beat   (nb),
                .o_beat      (ochain[j])
            );
        end
    endgenerate

    assign o_out_byte     = ochain[0].data;
    assign o_last_of_text = ochain[0].last;

    assign n_count = base + (in_acc ? ssr_pkg::CNT_W'(burst_n) : '0);

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill  <= '0;
            r_count <= '0;
        end else begin
            r_fill  <= n_fill;
            r_count <= n_count;
        end
    end

    `SSR_ASSERT_NOW(a_fill_below_len, 1'b1, ssr_pkg::LEN_W'(r_fill) < plen, "window fill reached pattern length")
    `SSR_ASSERT_NOW(a_count_bound, 1'b1, r_count <= ssr_pkg::CNT_W'(NO), "output chain overflow")
    `SSR_ASSERT_NEXT(a_match_clears, in_acc && match, r_fill == '0, "window not cleared after a match")
    `SSR_ASSERT_NEXT(a_drain_step, pop && !in_acc, r_count == $past(r_count) - ssr_pkg::CNT_W'(1), "output chain count did not step down")

endmodule

[tb/tb_stream_substring_replace.sv]
// Self-checking testbench for stream_substring_replace: directed and random texts.
// Depends on ssr_pkg and the stream_substring_replace RTL; predicts the rewritten
// text internally and compares every output beat against it.
`timescale 1ns / 1ps

module tb_stream_substring_replace;

    localparam int CLK_PERIOD     = 8;
    localparam int TIMEOUT_CYCLES = 1_000_000;
    localparam int PHASE_ITEMS    = 56;
    localparam int NUM_PHASES     = 7;
    localparam int SETTLE_CYCLES  = 4;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } t_text_out;

    logic                       i_clk;
    logic                       i_rst_n        = 1'b0;
    logic                       i_in_valid     = 1'b0;
    logic [7:0]                 i_text_byte    = '0;
    logic                       i_end_of_text  = 1'b0;
    logic                       i_out_ready    = 1'b0;
    logic                       psel           = 1'b0;
    logic                       penable        = 1'b0;
    logic                       pwrite         = 1'b0;
    logic [ssr_pkg::ADDR_W-1:0] paddr          = '0;
    logic [ssr_pkg::DATA_W-1:0] pwdata         = '0;
    logic                       o_in_ready;
    logic                       o_out_valid;
    logic [7:0]                 o_out_byte;
    logic                       o_last_of_text;
    logic [ssr_pkg::DATA_W-1:0] prdata;
    logic                       pready;

    // Predictor state: register copies and pending window
    logic [63:0] pat_bytes = '0;
    logic [3:0]  pat_len   = 4'd1;
    logic [63:0] rep_bytes = '0;
    logic [3:0]  rep_len   = 4'd0;
    logic [7:0]  pending [8];
    int          win_fill  = 0;

    t_text_out rewritten_q[$];
    int        fail_count      = 0;
    int        text_items_sent = 0;
    bit        gaps_on         = 1'b1;
    bit        stall_on        = 1'b1;
    int        sink_hold       = 0;

    stream_substring_replace dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_text_byte    (i_text_byte),
        .i_end_of_text  (i_end_of_text),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_out_byte     (o_out_byte),
        .o_last_of_text (o_last_of_text),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready)
    );

    initial begin
        i_clk = 1'b0;
        forever #(CLK_PERIOD / 2) i_clk = ~i_clk;
    end

    initial begin
        #(CLK_PERIOD * TIMEOUT_CYCLES);
        $display("stream_substring_replace verification failed");
        $finish;
    end

    // Idle length: mostly none or short, now and then long
    function automatic int idle_length(input bit enabled);
        int r;
        if (!enabled) return 0;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 30);
    endfunction

    // Pattern length in effect: zero acts as one, cap at the window size
    function automatic int pattern_len_now();
        if (pat_len == 4'd0) return 1;
        if (pat_len > ssr_pkg::MAX_PATTERN) return ssr_pkg::MAX_PATTERN;
        return pat_len;
    endfunction

    task automatic report_failure(input string msg);
        fail_count++;
        if (fail_count <= 10) $display("[%0t] mismatch: %s", $realtime, msg);
    endtask

    // Advance the window by one text byte and queue the bytes it releases
    task automatic rewrite_text_byte(input logic [7:0] b, input logic eot);
        t_text_out burst[$];
        int        plen;
        int        rlen;
        int        i;
        bit        hit;
        plen = pattern_len_now();
        rlen = (rep_len > ssr_pkg::MAX_REPLACEMENT) ? ssr_pkg::MAX_REPLACEMENT : rep_len;
        if (win_fill >= plen) win_fill = 0;
        pending[win_fill] = b;
        win_fill++;
        if (win_fill == plen) begin
            hit = 1'b1;
            for (i = 0; i < plen; i++) begin
                if (pending[i] != pat_bytes[8*i +: 8]) hit = 1'b0;
            end
            if (hit) begin
                for (i = 0; i < rlen; i++) burst.push_back('{rep_bytes[8*i +: 8], 1'b0});
                win_fill = 0;
            end else begin
                // Release the oldest byte and shift the rest down
                burst.push_back('{pending[0], 1'b0});
                for (i = 1; i < plen; i++) pending[i-1] = pending[i];
                win_fill--;
            end
        end
        if (eot) begin
            for (i = 0; i < win_fill; i++) burst.push_back('{pending[i], 1'b0});
            win_fill = 0;
            if (burst.size() > 0) burst[burst.size()-1].last = 1'b1;
        end
        foreach (burst[k]) rewritten_q.push_back(burst[k]);
    endtask

    // Receiver: random stall stretches on the output channel
    always @(posedge i_clk) begin
        if (sink_hold > 0) begin
            i_out_ready <= 1'b0;
            sink_hold   <= sink_hold - 1;
        end else begin
            i_out_ready <= 1'b1;
            sink_hold   <= idle_length(stall_on);
        end
    end

    // Predict on each input beat, then check each output beat against the oldest expectation
    always @(posedge i_clk) begin
        t_text_out want;
        if (i_rst_n) begin
            if (i_in_valid && o_in_ready) rewrite_text_byte(i_text_byte, i_end_of_text);
            if (o_out_valid && i_out_ready) begin
                if (rewritten_q.size() == 0) begin
                    report_failure($sformatf("unexpected beat byte=%02h last=%0b",
                                             o_out_byte, o_last_of_text));
                end else begin
                    want = rewritten_q.pop_front();
                    if (want.data !== o_out_byte)
                        report_failure($sformatf("out_byte expected %02h got %02h",
                                                 want.data, o_out_byte));
                    if (want.last !== o_last_of_text)
                        report_failure($sformatf("last_of_text expected %0b got %0b (byte %02h)",
                                                 want.last, o_last_of_text, want.data));
                end
            end
        end
    end

    // Send one text byte; returns at the edge that accepts it
    task automatic send_text_byte(input logic [7:0] b, input logic eot);
        int gap;
        gap = idle_length(gaps_on);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_text_byte   <= b;
        i_end_of_text <= eot;
        do @(posedge i_clk); while (!o_in_ready);
        text_items_sent++;
    endtask

    // Drop valid and hold until every expected beat has arrived
    task automatic drain_results(input int settle);
        i_in_valid <= 1'b0;
        // Let the predictor take the last accepted beat first
        @(posedge i_clk);
        while (rewritten_q.size() != 0) @(posedge i_clk);
        repeat (settle) @(posedge i_clk);
    endtask

    // APB write: setup cycle, access cycle, then update the predictor's copy
    task automatic write_register(input ssr_pkg::t_reg_idx idx, input logic [63:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 3'b000};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            ssr_pkg::REG_PATTERN_BYTES:     pat_bytes = value;
            ssr_pkg::REG_PATTERN_LENGTH: begin
                pat_len = value[3:0];
                // Window already as long as the new pattern: discard it
                if (win_fill >= pattern_len_now()) win_fill = 0;
            end
            ssr_pkg::REG_REPLACEMENT_BYTES: rep_bytes = value;
            ssr_pkg::REG_REPLACEMENT_LENGTH: rep_len = value[3:0];
            default: ;
        endcase
    endtask

    // Random text drawn mostly from the pattern: whole copies, prefixes, stray bytes
    task automatic send_text(input int len);
        int         k;
        int         j;
        int         r;
        int         plen;
        int         cut;
        logic [7:0] b;
        plen = pattern_len_now();
        k    = 0;
        while (k < len) begin
            r = $urandom_range(0, 9);
            if (r < 4) begin
                cut = ($urandom_range(0, 3) == 0) ? $urandom_range(1, plen) : plen;
                for (j = 0; j < cut && k < len; j++) begin
                    send_text_byte(pat_bytes[8*j +: 8], k == len - 1);
                    k++;
                end
            end else begin
                if (r < 7) b = pat_bytes[8*$urandom_range(0, plen - 1) +: 8];
                else b = 8'($urandom_range(0, 255));
                send_text_byte(b, k == len - 1);
                k++;
            end
        end
    endtask

    // Reset values: single zero byte pattern, empty replacement
    task automatic test_reset_defaults();
        send_text_byte(8'hFF, 1'b0);
        send_text_byte(8'h00, 1'b0);
        send_text_byte(8'h80, 1'b1);
        // Match deleted at the very end leaves an empty end
        send_text_byte(8'h00, 1'b1);
        drain_results(SETTLE_CYCLES);
    endtask

    // Lengths above range clamp to eight; full window match gives the longest burst
    task automatic test_longest_burst();
        logic [63:0] pat;
        int          i;
        pat = 64'hFF00_7F80_0102_03FE;
        write_register(ssr_pkg::REG_PATTERN_BYTES, pat);
        write_register(ssr_pkg::REG_PATTERN_LENGTH, 64'hF);
        write_register(ssr_pkg::REG_REPLACEMENT_BYTES, 64'h0123_4567_89AB_CDEF);
        write_register(ssr_pkg::REG_REPLACEMENT_LENGTH, 64'hF);
        send_text_byte(8'h55, 1'b0);
        for (i = 0; i < 8; i++) send_text_byte(pat[8*i +: 8], i == 7);
        drain_results(SETTLE_CYCLES);
    endtask

    // Pattern length changed with bytes pending: discarded or kept
    task automatic test_length_change_mid_text();
        write_register(ssr_pkg::REG_PATTERN_BYTES, 64'h0063_6261);
        write_register(ssr_pkg::REG_PATTERN_LENGTH, 64'd3);
        write_register(ssr_pkg::REG_REPLACEMENT_BYTES, 64'h5958);
        write_register(ssr_pkg::REG_REPLACEMENT_LENGTH, 64'd2);
        send_text_byte(8'h61, 1'b0);
        send_text_byte(8'h62, 1'b0);
        drain_results(SETTLE_CYCLES);
        write_register(ssr_pkg::REG_PATTERN_LENGTH, 64'd2);
        send_text_byte(8'h63, 1'b1);
        send_text_byte(8'h71, 1'b0);
        drain_results(SETTLE_CYCLES);
        write_register(ssr_pkg::REG_PATTERN_LENGTH, 64'd3);
        send_text_byte(8'h72, 1'b1);
        drain_results(SETTLE_CYCLES);
        // Zero length acts as one
        write_register(ssr_pkg::REG_PATTERN_LENGTH, 64'd0);
        send_text_byte(8'h61, 1'b1);
        drain_results(SETTLE_CYCLES);
    endtask

    // Random texts over several settings, extremes first
    task automatic test_random_texts();
        int  phase;
        int  phase_start;
        int  len;
        bit  paused;
        paused = 1'b0;
        for (phase = 0; phase < NUM_PHASES; phase++) begin
            case (phase)
                0: begin
                    write_register(ssr_pkg::REG_PATTERN_BYTES, 64'h0);
                    write_register(ssr_pkg::REG_PATTERN_LENGTH, 64'd1);
                    write_register(ssr_pkg::REG_REPLACEMENT_BYTES, '1);
                    write_register(ssr_pkg::REG_REPLACEMENT_LENGTH, 64'd8);
                end
                1: begin
                    write_register(ssr_pkg::REG_PATTERN_BYTES, '1);
                    write_register(ssr_pkg::REG_PATTERN_LENGTH, 64'd8);
                    write_register(ssr_pkg::REG_REPLACEMENT_BYTES, {$urandom, $urandom});
                    write_register(ssr_pkg::REG_REPLACEMENT_LENGTH, 64'd0);
                end
                2: begin
                    write_register(ssr_pkg::REG_PATTERN_BYTES, {$urandom, $urandom});
                    write_register(ssr_pkg::REG_PATTERN_LENGTH, 64'd15);
                    write_register(ssr_pkg::REG_REPLACEMENT_BYTES, {$urandom, $urandom});
                    write_register(ssr_pkg::REG_REPLACEMENT_LENGTH, 64'd12);
                end
                default: begin
                    write_register(ssr_pkg::REG_PATTERN_BYTES, {$urandom, $urandom});
                    write_register(ssr_pkg::REG_PATTERN_LENGTH, 64'($urandom_range(0, 9)));
                    write_register(ssr_pkg::REG_REPLACEMENT_BYTES, {$urandom, $urandom});
                    write_register(ssr_pkg::REG_REPLACEMENT_LENGTH,
                                   64'($urandom_range(0, 10)));
                end
            endcase
            // Every third phase runs with no idling on either side
            gaps_on     = (phase % 3) != 0;
            stall_on    = (phase % 3) != 0;
            phase_start = text_items_sent;
            while (text_items_sent - phase_start < PHASE_ITEMS) begin
                len = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 3)
                                                  : $urandom_range(4, 24);
                send_text(len);
                // Hold the sender once until the output side is empty
                if (phase == 3 && !paused && text_items_sent - phase_start >= PHASE_ITEMS / 2) begin
                    paused = 1'b1;
                    drain_results(0);
                end
            end
            drain_results(SETTLE_CYCLES);
        end
    endtask

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_reset_defaults();
        test_longest_burst();
        test_length_change_mid_text();
        test_random_texts();
        drain_results(2 * SETTLE_CYCLES);
        if (fail_count == 0) begin
            $display("stream_substring_replace verification clean");
        end else begin
            $display("stream_substring_replace verification failed");
        end
        $finish;
    end

endmodule
